// ===== sv/crd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types, register codes and Q8.24 helpers for the reaction-diffusion
// stencil step.
// ----------------------------------------------------------------------------
package crd_pkg;

    typedef struct packed {
        logic signed [31:0] old_excitation;
        logic signed [31:0] old_recovery;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_excitation;
        logic signed [31:0] new_recovery;
        logic [7:0]         cell_row;
        logic [7:0]         cell_col;
        logic               run_last;
    } out_t;

    // one cell to evaluate: four neighbors, center, old recovery, tag
    typedef struct packed {
        logic signed [31:0] nb_left;
        logic signed [31:0] nb_right;
        logic signed [31:0] nb_up;
        logic signed [31:0] nb_down;
        logic signed [31:0] center;
        logic signed [31:0] recovery;
        logic [7:0]         row;
        logic [7:0]         col;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [8:0]  grid_cols;
        logic [8:0]  grid_rows;
        logic [30:0] diffusion_gain;
        logic [30:0] time_step;
        logic [30:0] reaction_gain;
        logic [30:0] recovery_rate;
        logic [30:0] recovery_scale;
        logic [30:0] recovery_offset;
    } cfg_t;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_GAIN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REACTION_GAIN   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_SCALE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_OFFSET = 4'd7;

    localparam cfg_t CFG_RESET = '{
        grid_cols:       9'd256,
        grid_rows:       9'd256,
        diffusion_gain:  31'd0,
        time_step:       31'd0,
        reaction_gain:   31'd134217728,
        recovery_rate:   31'd167772,
        recovery_scale:  31'd1174405,
        recovery_offset: 31'd5033165
    };

    localparam logic signed [39:0] Q_ONE   = 40'sd16777216;
    localparam logic signed [39:0] Q_TENTH = 40'sd1677722;

    localparam logic signed [39:0] SAT_HI = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] SAT_LO = 40'shFF_8000_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    function automatic logic signed [31:0] sat40(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(x[31:0]);
        end
        return r;
    endfunction

    // product back to Q8.24: floor shift by 24, then saturate
    function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
        logic signed [63:0] sh;
        sh = p >>> 24;
        return sat40($signed(sh[39:0]));
    endfunction

endpackage
`default_nettype wire

// ===== sv/cardiac_reaction_diffusion_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cardiac_reaction_diffusion_step
// One explicit Aliev-Panfilov time step over a raster-ordered grid stream.
// ----------------------------------------------------------------------------
// Cells enter in raster order; each new cell comes out as soon as its four
// neighbors have arrived, tagged with row and column, and run_last marks the
// last result of an item, which yields up to three results on the last row.
// The gathering front takes a new input item only once it has pushed the
// jobs of the last one, and may wait for room in the job queue. The
// arithmetic back works on one job at a time; its pace is set by the 56-step
// bit-serial divider, which a zero recovery divisor skips, and the single
// shared multiplier. A four-entry job queue lets the front keep accepting
// while the back works. Line buffers hold no reset value: a grid size change
// in the middle of a frame reads stale entries.
// ----------------------------------------------------------------------------
module cardiac_reaction_diffusion_step
    import crd_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    cfg_t cfg_reg;
    logic front_valid, front_ready, back_valid, back_ready;
    job_t front_job, back_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GRID_COLS:       cfg_reg.grid_cols       <= cfg_data[8:0];
                CFG_GRID_ROWS:       cfg_reg.grid_rows       <= cfg_data[8:0];
                CFG_DIFFUSION_GAIN:  cfg_reg.diffusion_gain  <= cfg_data[30:0];
                CFG_TIME_STEP:       cfg_reg.time_step       <= cfg_data[30:0];
                CFG_REACTION_GAIN:   cfg_reg.reaction_gain   <= cfg_data[30:0];
                CFG_RECOVERY_RATE:   cfg_reg.recovery_rate   <= cfg_data[30:0];
                CFG_RECOVERY_SCALE:  cfg_reg.recovery_scale  <= cfg_data[30:0];
                CFG_RECOVERY_OFFSET: cfg_reg.recovery_offset <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    crd_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    crd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    crd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== sv/crd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crd_div
// Bit-serial signed divider: (dividend * 2^24) / divisor, truncated toward
// zero and saturated to 32 bits; a zero divisor saturates by the sign.
// ----------------------------------------------------------------------------
module crd_div
    import crd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] dividend,
    input  wire logic signed [31:0] divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);

    localparam int DIV_STEPS = 56;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic              busy_reg, fin_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [31:0]       rem_reg;
    logic [DIV_STEPS-1:0] dq_reg;
    logic [31:0]       mag_reg;
    logic              neg_reg;
    logic signed [31:0] q_reg;

    logic [31:0] abs_n, abs_d;
    logic [32:0] rem_sh;
    logic        fits;
    logic [32:0] rem_sub;

    assign abs_n   = dividend[31] ? (~dividend + 32'd1) : dividend;
    assign abs_d   = divisor[31] ? (~divisor + 32'd1) : divisor;
    assign rem_sh  = {rem_reg, dq_reg[DIV_STEPS-1]};
    assign fits    = rem_sh >= {1'b0, mag_reg};
    assign rem_sub = rem_sh - {1'b0, mag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= (divisor != 32'sd0);
            done_reg <= (divisor == 32'sd0);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= {abs_n, 24'd0};
            mag_reg <= abs_d;
            neg_reg <= dividend[31] ^ divisor[31];
            if (divisor == 32'sd0) begin
                if (dividend > 32'sd0) begin
                    q_reg <= 32'sh7FFF_FFFF;
                end else if (dividend < 32'sd0) begin
                    q_reg <= 32'sh8000_0000;
                end else begin
                    q_reg <= 32'sd0;
                end
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[31:0] : rem_sh[31:0];
            dq_reg  <= {dq_reg[DIV_STEPS-2:0], fits};
        end else if (fin_reg) begin
            // apply sign, saturate the magnitude
            if (neg_reg) begin
                if (dq_reg > DIV_STEPS'(32'h8000_0000)) begin
                    q_reg <= 32'sh8000_0000;
                end else begin
                    q_reg <= $signed(32'd0 - dq_reg[31:0]);
                end
            end else begin
                if (dq_reg > DIV_STEPS'(32'h7FFF_FFFF)) begin
                    q_reg <= 32'sh7FFF_FFFF;
                end else begin
                    q_reg <= $signed(dq_reg[31:0]);
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// ===== sv/crd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crd_front
// Raster position tracking, line buffers and neighbor gathering; turns each
// input item into zero to three cell jobs.
// ----------------------------------------------------------------------------
module crd_front
    import crd_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      job_valid,
    input  wire logic job_ready,
    output job_t      job
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CSW = CW + 1;
    localparam int RSW = RW + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD0    = 4'd1;
    localparam logic [3:0] ST_RD1    = 4'd2;
    localparam logic [3:0] ST_RD2    = 4'd3;
    localparam logic [3:0] ST_PUSH_A = 4'd4;
    localparam logic [3:0] ST_LR0    = 4'd5;
    localparam logic [3:0] ST_LR1    = 4'd6;
    localparam logic [3:0] ST_LR2    = 4'd7;
    localparam logic [3:0] ST_PUSH_B = 4'd8;
    localparam logic [3:0] ST_PUSH_C = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] cur_c_reg;
    logic [RW-1:0] cur_r_reg;
    logic signed [31:0] e_reg, rv_reg, mid_reg, up_reg, rec_reg, left_hold_reg;
    logic          last_row_reg, col_end_reg;
    job_t          job_reg;

    logic signed [31:0] row_one_mem  [MAX_COLS];
    logic signed [31:0] row_two_mem  [MAX_COLS];
    logic signed [31:0] recovery_mem [MAX_COLS];
    logic signed [31:0] row_one_q, row_two_q, recovery_q;
    logic [CW-1:0] row_one_raddr, line_raddr;
    logic          line_we;

    logic [CSW-1:0] cols_eff;
    logic [RSW-1:0] rows_eff;
    logic           accept, restart, col_wrap;
    logic [CW-1:0]  c_start;
    logic [RW-1:0]  r_start;
    job_t           job_a, job_b, job_c;

    // grid size clamped to [2, MAX]
    always_comb begin
        if (cfg.grid_cols < 9'd2) begin
            cols_eff = CSW'(2);
        end else if ({23'd0, cfg.grid_cols} > 32'(MAX_COLS)) begin
            cols_eff = CSW'(MAX_COLS);
        end else begin
            cols_eff = CSW'(cfg.grid_cols);
        end
        if (cfg.grid_rows < 9'd2) begin
            rows_eff = RSW'(2);
        end else if ({23'd0, cfg.grid_rows} > 32'(MAX_ROWS)) begin
            rows_eff = RSW'(MAX_ROWS);
        end else begin
            rows_eff = RSW'(cfg.grid_rows);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // restart the raster when the position fell outside the grid
    assign restart  = ({1'b0, col_count_reg} >= cols_eff) ||
                      ({1'b0, row_count_reg} >= rows_eff);
    assign c_start  = restart ? '0 : col_count_reg;
    assign r_start  = restart ? '0 : row_count_reg;
    assign col_wrap = ({1'b0, c_start} + CSW'(1)) >= cols_eff;

    always_comb begin
        if (col_wrap) begin
            col_count_next = '0;
            if (({1'b0, r_start} + RSW'(1)) >= rows_eff) begin
                row_count_next = '0;
            end else begin
                row_count_next = r_start + RW'(1);
            end
        end else begin
            col_count_next = c_start + CW'(1);
            row_count_next = r_start;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_RD1:  row_one_raddr = (cur_c_reg == '0) ? CW'(1) : cur_c_reg + CW'(1);
            ST_LR0:  row_one_raddr = cur_c_reg - CW'(1);
            ST_LR1:  row_one_raddr = (cur_c_reg == CW'(1)) ? CW'(1) : cur_c_reg - CW'(2);
            default: row_one_raddr = cur_c_reg;
        endcase
    end

    assign line_raddr = (state_reg == ST_LR0) ? cur_c_reg - CW'(1) : cur_c_reg;
    assign line_we    = (state_reg == ST_RD2);

    always_ff @(posedge aclk) begin
        if (line_we) begin
            row_one_mem[cur_c_reg]  <= e_reg;
            row_two_mem[cur_c_reg]  <= mid_reg;
            recovery_mem[cur_c_reg] <= rv_reg;
        end
        row_one_q  <= row_one_mem[row_one_raddr];
        row_two_q  <= row_two_mem[line_raddr];
        recovery_q <= recovery_mem[line_raddr];
    end

    // cell one row up, completed by the arriving item
    always_comb begin
        job_a.nb_left  = (cur_c_reg == '0) ? row_one_q : left_hold_reg;
        job_a.nb_right = col_end_reg ? left_hold_reg : row_one_q;
        job_a.nb_up    = (cur_r_reg == RW'(1)) ? e_reg : up_reg;
        job_a.nb_down  = e_reg;
        job_a.center   = mid_reg;
        job_a.recovery = rec_reg;
        job_a.row      = 8'(cur_r_reg - RW'(1));
        job_a.col      = 8'(cur_c_reg);
        job_a.last     = !(last_row_reg && (cur_c_reg != '0));
    end

    // last row, one column to the left
    always_comb begin
        job_b.nb_left  = row_one_q;
        job_b.nb_right = e_reg;
        job_b.nb_up    = up_reg;
        job_b.nb_down  = up_reg;
        job_b.center   = mid_reg;
        job_b.recovery = rec_reg;
        job_b.row      = 8'(cur_r_reg);
        job_b.col      = 8'(cur_c_reg - CW'(1));
        job_b.last     = !col_end_reg;
    end

    // last row, last column
    always_comb begin
        job_c.nb_left  = mid_reg;
        job_c.nb_right = mid_reg;
        job_c.nb_up    = left_hold_reg;
        job_c.nb_down  = left_hold_reg;
        job_c.center   = e_reg;
        job_c.recovery = rv_reg;
        job_c.row      = 8'(cur_r_reg);
        job_c.col      = 8'(cur_c_reg);
        job_c.last     = 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_RD0;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = (cur_r_reg != '0) ? ST_PUSH_A : ST_IDLE;
            ST_PUSH_A: begin
                if (job_ready) begin
                    state_next = (last_row_reg && (cur_c_reg != '0)) ? ST_LR0 : ST_IDLE;
                end
            end
            ST_LR0:    state_next = ST_LR1;
            ST_LR1:    state_next = ST_LR2;
            ST_LR2:    state_next = ST_PUSH_B;
            ST_PUSH_B: begin
                if (job_ready) begin
                    state_next = col_end_reg ? ST_PUSH_C : ST_IDLE;
                end
            end
            ST_PUSH_C: if (job_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_c_reg    <= c_start;
            cur_r_reg    <= r_start;
            e_reg        <= s_data.old_excitation;
            rv_reg       <= s_data.old_recovery;
            last_row_reg <= ({1'b0, r_start} == rows_eff - RSW'(1));
            col_end_reg  <= ({1'b0, c_start} == cols_eff - CSW'(1));
        end
        if (state_reg == ST_RD1 || state_reg == ST_LR1) begin
            mid_reg <= row_one_q;
            up_reg  <= row_two_q;
            rec_reg <= recovery_q;
        end
        if (state_reg == ST_RD2) begin
            left_hold_reg <= mid_reg;
            job_reg       <= job_a;
        end
        if (state_reg == ST_LR2) begin
            job_reg <= job_b;
        end
        if (state_reg == ST_PUSH_B && job_ready) begin
            job_reg <= job_c;
        end
    end

    assign job_valid = (state_reg == ST_PUSH_A) || (state_reg == ST_PUSH_B) ||
                       (state_reg == ST_PUSH_C);
    assign job       = job_reg;

endmodule
`default_nettype wire

// ===== sv/crd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crd_queue
// Short job queue between the gathering front and the arithmetic back.
// ----------------------------------------------------------------------------
module crd_queue
    import crd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire job_t in_job,
    output logic      out_valid,
    input  wire logic out_ready,
    output job_t      out_job
);

    job_t                slot_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push, pop;

    assign in_ready  = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = slot_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop) begin
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_mem[wr_ptr_reg] <= in_job;
    end

endmodule
`default_nettype wire

// ===== sv/crd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crd_back
// Cell update sequencer: Laplacian, cubic reaction and recovery on one
// shared 32x32 multiplier and the serial divider, with a result register.
// ----------------------------------------------------------------------------
module crd_back
    import crd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SUM   = 5'd1;
    localparam logic [4:0] ST_LAP   = 5'd2;
    localparam logic [4:0] ST_M_ALAP = 5'd3;
    localparam logic [4:0] ST_E1    = 5'd4;
    localparam logic [4:0] ST_T12   = 5'd5;
    localparam logic [4:0] ST_P1    = 5'd6;
    localparam logic [4:0] ST_M_P2  = 5'd7;
    localparam logic [4:0] ST_P2    = 5'd8;
    localparam logic [4:0] ST_M_P3  = 5'd9;
    localparam logic [4:0] ST_P3    = 5'd10;
    localparam logic [4:0] ST_M_ER  = 5'd11;
    localparam logic [4:0] ST_S     = 5'd12;
    localparam logic [4:0] ST_M_DTS = 5'd13;
    localparam logic [4:0] ST_E2    = 5'd14;
    localparam logic [4:0] ST_DEN   = 5'd15;
    localparam logic [4:0] ST_NUM   = 5'd16;
    localparam logic [4:0] ST_W1    = 5'd17;
    localparam logic [4:0] ST_M_W   = 5'd18;
    localparam logic [4:0] ST_H     = 5'd19;
    localparam logic [4:0] ST_DIVW  = 5'd20;
    localparam logic [4:0] ST_M_DTG = 5'd21;
    localparam logic [4:0] ST_TG    = 5'd22;
    localparam logic [4:0] ST_M_TGH = 5'd23;
    localparam logic [4:0] ST_NR    = 5'd24;
    localparam logic [4:0] ST_OUT   = 5'd25;

    logic [4:0] state_reg, state_next;
    job_t       job_reg;
    logic signed [63:0] prod_reg;
    logic signed [39:0] sum_reg;
    logic signed [31:0] lap_reg, e1_reg, t1_reg, t2_reg, tmp_reg, s_reg;
    logic signed [31:0] e2_reg, den_reg, num_reg, c1_reg, h_reg, g_reg, nr_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;

    logic signed [31:0] mul_a, mul_b, qp;
    logic signed [63:0] mul_p;
    logic signed [31:0] alpha, dt, kk, eps, m1, m2;
    logic signed [39:0] mid40, rec40;
    logic       div_done;
    logic signed [31:0] div_q;
    logic       out_load;

    assign alpha = $signed({1'b0, cfg.diffusion_gain});
    assign dt    = $signed({1'b0, cfg.time_step});
    assign kk    = $signed({1'b0, cfg.reaction_gain});
    assign eps   = $signed({1'b0, cfg.recovery_rate});
    assign m1    = $signed({1'b0, cfg.recovery_scale});
    assign m2    = $signed({1'b0, cfg.recovery_offset});

    assign mid40 = 40'(job_reg.center);
    assign rec40 = 40'(job_reg.recovery);
    assign qp    = qmul_sat(prod_reg);

    crd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_W1),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        unique case (state_reg)
            ST_M_ALAP: begin mul_a = alpha;   mul_b = lap_reg;          end
            ST_T12:    begin mul_a = kk;      mul_b = e1_reg;           end
            ST_M_P2:   begin mul_a = tmp_reg; mul_b = t1_reg;           end
            ST_M_P3:   begin mul_a = tmp_reg; mul_b = t2_reg;           end
            ST_M_ER:   begin mul_a = e1_reg;  mul_b = job_reg.recovery; end
            ST_M_DTS:  begin mul_a = dt;      mul_b = s_reg;            end
            ST_DEN:    begin mul_a = m1;      mul_b = job_reg.recovery; end
            ST_NUM:    begin mul_a = kk;      mul_b = e2_reg;           end
            ST_M_W:    begin mul_a = tmp_reg; mul_b = c1_reg;           end
            ST_M_DTG:  begin mul_a = dt;      mul_b = g_reg;            end
            ST_M_TGH:  begin mul_a = tmp_reg; mul_b = h_reg;            end
            default:   begin mul_a = tmp_reg; mul_b = tmp_reg;          end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign job_ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_valid) state_next = ST_SUM;
            ST_DIVW:  if (div_done) state_next = ST_M_DTG;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            ST_SUM, ST_LAP, ST_M_ALAP, ST_E1, ST_T12, ST_P1, ST_M_P2, ST_P2,
            ST_M_P3, ST_P3, ST_M_ER, ST_S, ST_M_DTS, ST_E2, ST_DEN, ST_NUM,
            ST_W1, ST_M_W, ST_H, ST_M_DTG, ST_TG, ST_M_TGH, ST_NR: begin
                state_next = state_reg + 5'd1;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (state_reg)
            ST_IDLE:  if (job_valid) job_reg <= job;
            ST_SUM:   sum_reg <= 40'(job_reg.nb_left) + 40'(job_reg.nb_right) +
                                 40'(job_reg.nb_up) + 40'(job_reg.nb_down);
            ST_LAP:   lap_reg <= sat40(sum_reg - (mid40 <<< 2));
            ST_E1:    e1_reg  <= sat40(mid40 + 40'(qp));
            ST_T12: begin
                t1_reg <= sat40(40'(e1_reg) - Q_TENTH);
                t2_reg <= sat40(40'(e1_reg) - Q_ONE);
            end
            ST_P1, ST_P2, ST_P3, ST_W1, ST_TG: tmp_reg <= qp;
            ST_S:     s_reg   <= sat40(40'(tmp_reg) + 40'(qp));
            ST_E2:    e2_reg  <= sat40(40'(e1_reg) - 40'(qp));
            ST_DEN: begin
                den_reg <= sat40(40'(e2_reg) + 40'(m2));
                c1_reg  <= sat40(40'(e2_reg) - Q_TENTH - Q_ONE);
            end
            ST_NUM:   num_reg <= qp;
            ST_H:     h_reg   <= sat40(-rec40 - 40'(qp));
            ST_DIVW:  if (div_done) g_reg <= sat40(40'(eps) + 40'(div_q));
            ST_NR:    nr_reg  <= sat40(rec40 + 40'(qp));
            default: ;
        endcase
        if (out_load) begin
            m_data_reg.new_excitation <= e2_reg;
            m_data_reg.new_recovery   <= nr_reg;
            m_data_reg.cell_row       <= job_reg.row;
            m_data_reg.cell_col       <= job_reg.col;
            m_data_reg.run_last       <= job_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
